[hdl/cacdp_pkg.sv]
// cacdp_pkg: shared constants, types and the control state type for the
// constrained array counting engine. No dependencies.
package cacdp_pkg;

  localparam int N_VALUES = 128;
  localparam int COUNT_W  = 30;
  localparam int ELEM_W   = 8;
  localparam int CFG_W    = 8;
  localparam int IDX_W    = (N_VALUES > 1) ? $clog2(N_VALUES) : 1;
  localparam int VAL_W    = $clog2(N_VALUES + 1);
  localparam int CMP_W    = (VAL_W > CFG_W) ? VAL_W : CFG_W;
  localparam int SUM_W    = COUNT_W + 2;

  localparam logic [COUNT_W-1:0] MODULUS = COUNT_W'(1000000007);

  // per-cell control word driven from the top level
  typedef struct packed {
    logic load;       // item accepted this cycle
    logic shift;      // rotate row toward cell 0
    logic allowed;    // value allowed by the item
    logic init;       // first element of an array
    logic use_left;   // neighbor below lies in range
    logic use_right;  // neighbor above lies in range
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SUM,
    ST_HOLD
  } state_t;

endpackage

[hdl/cacdp_in_if.sv]
// cacdp_in_if: input item channel (element, first, last) with valid/ready.
// Depends on cacdp_pkg for field widths.
interface cacdp_in_if import cacdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              first;
  logic              last;

  modport source (output valid, element, first, last, input ready);
  modport sink   (input valid, element, first, last, output ready);
endinterface

[hdl/cacdp_out_if.sv]
// cacdp_out_if: result item channel (count) with valid/ready.
// Depends on cacdp_pkg for field widths.
interface cacdp_out_if import cacdp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

[hdl/cacdp_cell.sv]
// cacdp_cell: one value's count with its modular neighbor update and the
// rotate path used while the row is summed. Depends on cacdp_pkg.
module cacdp_cell import cacdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [COUNT_W-1:0] left_val,
  input  logic [COUNT_W-1:0] right_val,
  output logic [COUNT_W-1:0] ways
);

  logic [COUNT_W-1:0] ways_r;
  logic [COUNT_W-1:0] ways_nxt;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   red;
  logic [SUM_W-1:0]   mod1;
  logic [SUM_W-1:0]   mod2;

  assign mod1 = SUM_W'(MODULUS);
  assign mod2 = SUM_W'(MODULUS) << 1;

  always_comb begin
    sum = SUM_W'(ways_r)
        + (ctl.use_left  ? SUM_W'(left_val)  : '0)
        + (ctl.use_right ? SUM_W'(right_val) : '0);
    // sum stays below three times the modulus
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    if (ctl.shift) begin
      ways_nxt = right_val;
    end else if (ctl.load) begin
      if (!ctl.allowed) begin
        ways_nxt = '0;
      end else if (ctl.init) begin
        ways_nxt = COUNT_W'(1);
      end else begin
        ways_nxt = red[COUNT_W-1:0];
      end
    end else begin
      ways_nxt = ways_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= '0;
    end else begin
      ways_r <= ways_nxt;
    end
  end

  assign ways = ways_r;

endmodule

[hdl/constrained_array_count_dp_top.sv]
// constrained_array_count_dp_top: row of count cells, summing accumulator
// and control. Depends on cacdp_pkg, cacdp_in_if, cacdp_out_if, cacdp_cell.
//
//  port      dir  handshake      payload
//  in_ch     in   valid/ready    element[7:0], first, last
//  out_ch    out  valid/ready    count[29:0]
//  cfg_*     in   cfg_we         cfg_wdata[7:0] = max_value
//
// an item without last updates every cell at once; an item with last is
// followed by a summing pass in which the row rotates through cell 0 into the
// accumulator, then ST_HOLD loads the result register once no earlier result
// is still untaken.
// input is stalled during the summing pass and ST_HOLD; rst_n is synchronous
// and clears the row, max_value returns to 100.
module constrained_array_count_dp_top import cacdp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cacdp_in_if.sink         in_ch,
  cacdp_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]   max_value_r;
  state_t             state_r;
  state_t             state_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   cnt_nxt;
  logic [COUNT_W-1:0] acc_r;
  logic [COUNT_W-1:0] acc_nxt;
  logic [COUNT_W:0]   acc_sum;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  logic               accept;
  logic               ready;
  logic               shift;
  logic               load_out;
  logic               cnt_done;
  logic [CMP_W-1:0]   m;
  logic [CMP_W-1:0]   elem_ext;

  logic [COUNT_W-1:0] ways [N_VALUES];

  assign accept   = in_ch.valid && ready;
  assign cnt_done = (cnt_r == IDX_W'(N_VALUES - 1));
  assign m        = (CMP_W'(max_value_r) > CMP_W'(N_VALUES)) ? CMP_W'(N_VALUES)
                                                             : CMP_W'(max_value_r);
  assign elem_ext = CMP_W'(in_ch.element);

  // row of cells, circular so the summing pass restores the row
  for (genvar i = 0; i < N_VALUES; i++) begin : g_cell
    localparam logic [CMP_W-1:0] V = CMP_W'(i + 1);
    cell_ctl_t ctl;

    always_comb begin
      ctl.load      = accept;
      ctl.shift     = shift;
      ctl.allowed   = (V <= m) && (elem_ext == '0 || elem_ext == V);
      ctl.init      = in_ch.first;
      ctl.use_left  = (i != 0);
      ctl.use_right = (V < m);
    end

    cacdp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_val  (ways[(i + N_VALUES - 1) % N_VALUES]),
      .right_val (ways[(i + 1) % N_VALUES]),
      .ways      (ways[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (accept && in_ch.last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    ready    = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_RUN:  ready = 1'b1;
      ST_SUM:  shift = 1'b1;
      ST_HOLD: load_out = !out_valid_r || out_ch.ready;
      default: ready = 1'b0;
    endcase
  end

  assign in_ch.ready = ready;

  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, ways[0]};
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    if (accept) begin
      cnt_nxt = '0;
      acc_nxt = '0;
    end else if (shift) begin
      cnt_nxt = cnt_r + IDX_W'(1);
      acc_nxt = (acc_sum >= (COUNT_W + 1)'(MODULUS))
              ? COUNT_W'(acc_sum - (COUNT_W + 1)'(MODULUS))
              : acc_sum[COUNT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      count_nxt     = acc_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      max_value_r <= CFG_W'(100);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      if (cfg_we) begin
        max_value_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.count = count_r;

`ifndef SYNTHESIS
  a_last_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last) |=> (state_r == ST_SUM))
    else $error("last item did not start the summing pass");

  a_sum_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && cnt_done) |=> (state_r == ST_HOLD))
    else $error("summing pass did not end after a full rotation");

  a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !in_ch.ready)
    else $error("item accepted during summing pass");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < MODULUS)
    else $error("accumulator out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");
`endif

endmodule

[tb/constrained_array_count_dp_top_tb.sv]
// constrained_array_count_dp_top_tb: self-checking bench for the array counting engine.
// Holds its own row-of-counts predictor in a scoreboard class, drives random arrays.
// Depends on cacdp_pkg, cacdp_in_if, cacdp_out_if and constrained_array_count_dp_top.
module constrained_array_count_dp_top_tb import cacdp_pkg::*; ;

  localparam int          CLK_HALF     = 5;
  localparam int          RESET_CYCLES = 7;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE       = 8;
  localparam int          PHASE_ITEMS  = 74;
  localparam int          NUM_PHASES   = 9;
  localparam logic [CFG_W-1:0] LIMIT_AT_RESET = CFG_W'(100);

  class count_scoreboard;
    logic [COUNT_W-1:0] ways [N_VALUES];
    logic [CFG_W-1:0]   limit;
    logic [COUNT_W-1:0] expected_counts [$];
    int                 errors;

    function new();
      foreach (ways[i]) ways[i] = '0;
      limit  = LIMIT_AT_RESET;
      errors = 0;
    endfunction

    // advance the row of counts by one accepted item
    function void note_input(logic [ELEM_W-1:0] elem, logic is_first, logic is_last);
      logic [COUNT_W-1:0] prev [N_VALUES];
      longint             acc;
      longint             total;
      int                 m;
      int                 v;
      m    = (int'(limit) > N_VALUES) ? N_VALUES : int'(limit);
      prev = ways;
      for (v = 1; v <= N_VALUES; v++) begin
        if (v > m || (elem != 0 && int'(elem) != v)) begin
          ways[v-1] = '0;
        end else if (is_first) begin
          ways[v-1] = COUNT_W'(1);
        end else begin
          acc = prev[v-1];
          if (v >= 2) acc += prev[v-2];
          if (v + 1 <= m) acc += prev[v];
          ways[v-1] = COUNT_W'(acc % longint'(MODULUS));
        end
      end
      if (is_last) begin
        total = 0;
        foreach (ways[i]) total = (total + ways[i]) % longint'(MODULUS);
        expected_counts.insert(expected_counts.size(), COUNT_W'(total));
      end
    endfunction

    function void check_count(logic [COUNT_W-1:0] actual);
      logic [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("unexpected result item: count %0d", actual);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (actual !== want) begin
          $error("count mismatch: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  cacdp_in_if  in_ch ();
  cacdp_out_if out_ch ();

  constrained_array_count_dp_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  count_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int cycles;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) sb.check_count(out_ch.count);
  end

  // called at a falling edge; valid stays high afterwards until the next idle cycle
  task automatic send_item(input logic [ELEM_W-1:0] elem, input logic is_first,
                           input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.element = elem;
    in_ch.first   = is_first;
    in_ch.last    = is_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(elem, is_first, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (sb.expected_counts.size() != 0) @(negedge clk);
    // an item without last may still be updating the row
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.limit  = value;
  endtask

  task automatic set_idle(input int phase);
    case (phase / 3)
      0: begin
        send_idle_pct = 12;
        recv_idle_pct = 83;
      end
      1: begin
        send_idle_pct = 83;
        recv_idle_pct = 12;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // mostly well-formed arrays with a random walk of values, the rest loose or broken
  task automatic send_random_array(input int m);
    int                kind;
    int                len;
    int                zero_pct;
    int                val;
    int                top;
    int                i;
    logic [ELEM_W-1:0] elem;
    kind = $urandom_range(99);
    top  = (m > 0) ? m : 1;
    if (kind < 20) begin
      len = $urandom_range(1, 3);
      for (i = 0; i < len; i++)
        send_item(ELEM_W'($urandom_range(0, N_VALUES)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end else begin
      len      = (kind < 30) ? $urandom_range(12, 40) : $urandom_range(1, 7);
      zero_pct = (kind < 30) ? 92 : 55;
      val      = $urandom_range(1, top);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(99) < 8) begin
          val = $urandom_range(1, N_VALUES);
        end else begin
          val = val + $urandom_range(0, 2) - 1;
          if (val < 1) val = 1;
          if (val > N_VALUES) val = N_VALUES;
        end
        elem = ($urandom_range(99) < zero_pct) ? '0 : ELEM_W'(val);
        // a few arrays lack the first mark, a few the last mark
        send_item(elem, (i == 0) && (kind >= 23), (i == len - 1) && (kind < 97));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] limits [NUM_PHASES];
    int               phase;
    int               start;
    int               m;

    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.element = '0;
    in_ch.first   = 1'b0;
    in_ch.last    = 1'b0;
    items_sent    = 0;
    set_idle(0);

    limits = '{CFG_W'(1), CFG_W'(128), CFG_W'(255), CFG_W'(0), CFG_W'(2), CFG_W'(3),
               CFG_W'($urandom_range(4, 127)), CFG_W'(127), CFG_W'(100)};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed items at the reset limit
    send_item(8'd0,   1'b0, 1'b1);  // no first mark after reset: row is all zero
    send_item(8'd0,   1'b1, 1'b1);
    send_item(8'd128, 1'b1, 1'b1);  // fixed value above the limit
    send_item(8'd100, 1'b1, 1'b1);
    send_item(8'd101, 1'b1, 1'b1);
    send_item(8'd1,   1'b1, 1'b0);
    send_item(8'd0,   1'b0, 1'b0);
    send_item(8'd2,   1'b0, 1'b1);
    send_item(8'd5,   1'b1, 1'b0);
    send_item(8'd7,   1'b0, 1'b1);
    send_item(8'd0,   1'b1, 1'b0);
    send_item(8'd0,   1'b0, 1'b0);
    send_item(8'd0,   1'b0, 1'b0);
    send_item(8'd0,   1'b0, 1'b1);
    send_item(8'd64,  1'b1, 1'b0);  // array without last, then restarted
    send_item(8'd32,  1'b1, 1'b0);
    send_item(8'd33,  1'b0, 1'b1);
    send_item(8'd16,  1'b1, 1'b0);
    send_item(8'd15,  1'b0, 1'b0);
    send_item(8'd8,   1'b0, 1'b1);
    send_item(8'd99,  1'b1, 1'b0);
    wait_drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // limit changes with an array still open
      write_limit(limits[phase]);
      set_idle(phase);
      m     = (int'(limits[phase]) > N_VALUES) ? N_VALUES : int'(limits[phase]);
      start = items_sent;
      send_item('0, 1'b0, 1'b0);
      send_item('0, 1'b0, 1'b1);
      while (items_sent - start < PHASE_ITEMS) begin
        send_random_array(m);
        if (phase == 4 && items_sent - start >= PHASE_ITEMS / 2 &&
            items_sent - start < PHASE_ITEMS / 2 + 8) begin
          wait_drain();
        end
      end
      send_item('0, 1'b1, 1'b0);
      send_item(ELEM_W'($urandom_range(1, N_VALUES)), 1'b0, 1'b0);
      wait_drain();
    end

    foreach (sb.expected_counts[i]) begin
      $error("expected count %0d never arrived", sb.expected_counts[i]);
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cacdp_pkg.sv
hdl/cacdp_in_if.sv
hdl/cacdp_out_if.sv
hdl/cacdp_cell.sv
hdl/constrained_array_count_dp_top.sv
tb/constrained_array_count_dp_top_tb.sv
